[rtl/bfrx_pkg.sv]
// Package for the byte frame receiver with XOR check.
// Holds field widths, register indexes and the controller/datapath structs.
// No dependencies.
package bfrx_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 6;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd1;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd2;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd3;

	typedef struct packed {
		logic take;
		logic clr_idx;
		logic inc_idx;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic frame_ok;
		logic empty;
		logic last;
		logic out_free;
	} status_t;

endpackage

[rtl/bfrx_if.sv]
// Channel interfaces: received byte stream, frame result stream, register write.
// Depends on bfrx_pkg for field widths.
interface bfrx_byte_if;
	logic                      valid;
	logic                      ready;
	logic [bfrx_pkg::BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface bfrx_frame_if;
	logic                       valid;
	logic                       ready;
	logic [bfrx_pkg::BYTE_W-1:0] packet_mode;
	logic [bfrx_pkg::BYTE_W-1:0] payload_byte;
	logic [bfrx_pkg::LEN_W-1:0]  payload_length;
	logic                       byte_present;
	logic                       last_of_packet;
	modport source (output valid, output packet_mode, output payload_byte,
		output payload_length, output byte_present, output last_of_packet, input ready);
	modport sink (input valid, input packet_mode, input payload_byte,
		input payload_length, input byte_present, input last_of_packet, output ready);
endinterface

interface bfrx_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bfrx_pkg::CFG_IDX_W-1:0] index;
	logic [bfrx_pkg::BYTE_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/bfrx_ctrl.sv]
// Controller: accepts bytes, then sequences payload store reads and result loads.
// Depends on bfrx_pkg for the command and status structs.
module bfrx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bfrx_pkg::status_t status,
	output bfrx_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_LOAD
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready     = (state_q == S_IDLE);
		cmd.take     = in_ready && in_valid;
		cmd.clr_idx  = cmd.take && status.frame_ok;
		cmd.load_out = (state_q == S_LOAD) && status.out_free;
		cmd.inc_idx  = cmd.load_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.take && status.frame_ok) begin
						state_q <= status.empty ? S_LOAD : S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (status.out_free) begin
						state_q <= (status.empty || status.last) ? S_IDLE : S_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/bfrx_datapath.sv]
// Datapath: frame parser registers, markers, payload store and result register.
// Depends on bfrx_pkg; driven by bfrx_ctrl through command and status structs.
module bfrx_datapath #(
	parameter int PAYLOAD_CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bfrx_pkg::BYTE_W-1:0]    rx_byte,
	input  logic                          cfg_valid,
	input  logic [bfrx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfrx_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bfrx_pkg::BYTE_W-1:0]    packet_mode,
	output logic [bfrx_pkg::BYTE_W-1:0]    payload_byte,
	output logic [bfrx_pkg::LEN_W-1:0]     payload_length,
	output logic                          byte_present,
	output logic                          last_of_packet,
	input  bfrx_pkg::cmd_t                cmd,
	output bfrx_pkg::status_t             status
);

	localparam int DEPTH = PAYLOAD_CAPACITY - 1;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [bfrx_pkg::LEN_W-1:0] DEPTH_L = bfrx_pkg::LEN_W'(DEPTH);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_MODE,
		PH_DATA,
		PH_SUM
	} phase_t;

	phase_t                       phase_q;
	logic [bfrx_pkg::BYTE_W-1:0] start_q;
	logic [bfrx_pkg::BYTE_W-1:0] end_q;
	logic [bfrx_pkg::BYTE_W-1:0] mode_q;
	logic [bfrx_pkg::BYTE_W-1:0] xor_q;
	logic [bfrx_pkg::LEN_W-1:0]  count_q;
	logic [bfrx_pkg::LEN_W-1:0]  idx_q;
	logic [bfrx_pkg::BYTE_W-1:0] rd_data_q;
	logic [bfrx_pkg::BYTE_W-1:0] mem [DEPTH];

	logic is_start;
	logic is_end;
	logic store_wr;

	assign is_start = (rx_byte == start_q);
	assign is_end   = (rx_byte == end_q);
	assign store_wr = cmd.take && !is_start && (phase_q == PH_DATA) && !is_end
		&& (count_q < DEPTH_L);

	always_comb begin
		status.frame_ok = !is_start && (phase_q == PH_SUM) && (xor_q == rx_byte);
		status.empty    = (count_q == '0);
		status.last     = ((idx_q + bfrx_pkg::LEN_W'(1)) == count_q);
		status.out_free = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= bfrx_pkg::START_MARKER_RST;
			end_q   <= bfrx_pkg::END_MARKER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bfrx_pkg::CFG_START_MARKER: start_q <= cfg_data;
				bfrx_pkg::CFG_END_MARKER:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			mode_q  <= '0;
			xor_q   <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			if (is_start) begin
				xor_q   <= '0;
				count_q <= '0;
				phase_q <= PH_MODE;
			end else begin
				unique case (phase_q)
					PH_MODE: begin
						mode_q  <= rx_byte;
						phase_q <= PH_DATA;
					end
					PH_DATA: begin
						if (is_end) begin
							phase_q <= PH_SUM;
						end else begin
							xor_q <= xor_q ^ rx_byte;
							if (count_q >= DEPTH_L) begin
								phase_q <= PH_HUNT;
							end else begin
								count_q <= count_q + bfrx_pkg::LEN_W'(1);
							end
						end
					end
					PH_SUM: begin
						phase_q <= PH_HUNT;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr) begin
			mem[count_q[IDX_W-1:0]] <= rx_byte;
		end
		rd_data_q <= mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.clr_idx) begin
			idx_q <= '0;
		end else if (cmd.inc_idx) begin
			idx_q <= idx_q + bfrx_pkg::LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			packet_mode    <= mode_q;
			payload_byte   <= status.empty ? '0 : rd_data_q;
			payload_length <= count_q;
			byte_present   <= !status.empty;
			last_of_packet <= status.empty || status.last;
		end
	end

endmodule

[rtl/byte_frame_receiver_xor_check_core.sv]
// Byte frame receiver with XOR check: top level joining controller and datapath.
// Bytes are taken while idle; a matching checksum byte starts a run of results, each
// a store read then a result load (only the load for an empty frame's result).
// A byte is not taken while a run is read out; the last result may wait unheld.
// Reset (arst_n, asynchronous): hunting phase, markers 2 and 3, no result pending.
// Depends on bfrx_pkg, bfrx_if, bfrx_ctrl and bfrx_datapath.
module byte_frame_receiver_xor_check_core #(
	parameter int PAYLOAD_CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	bfrx_byte_if.sink     rx,
	bfrx_frame_if.source  tx,
	bfrx_cfg_if.sink      cfg
);

	bfrx_pkg::cmd_t    cmd;
	bfrx_pkg::status_t status;

	assign cfg.ready = 1'b1;

	bfrx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.status   (status),
		.cmd      (cmd)
	);

	bfrx_datapath #(
		.PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx.rx_byte),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.out_ready      (tx.ready),
		.out_valid      (tx.valid),
		.packet_mode    (tx.packet_mode),
		.payload_byte   (tx.payload_byte),
		.payload_length (tx.payload_length),
		.byte_present   (tx.byte_present),
		.last_of_packet (tx.last_of_packet),
		.cmd            (cmd),
		.status         (status)
	);

endmodule
